FILE: rtl/core/tmt32_pkg.sv
// Shared types, constants, microcode table and TinyMT helper functions.
`default_nettype none

package tmt32_pkg;

   localparam int WORD_W     = 32;
   localparam int REQ_DATA_W = 160;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int PC_W       = 5;
   localparam int KONST_W    = 3;

   localparam logic [WORD_W-1:0] MAT1  = 32'h8f7011ee;
   localparam logic [WORD_W-1:0] MAT2  = 32'hfc78ff1f;
   localparam logic [WORD_W-1:0] TMAT  = 32'h3793fdff;
   localparam logic [WORD_W-1:0] MULT  = 32'h6c078965;
   localparam logic [WORD_W-1:0] MASK  = 32'h7fffffff;

   localparam logic [WORD_W-1:0] CERT0 = 32'd84;
   localparam logic [WORD_W-1:0] CERT1 = 32'd73;
   localparam logic [WORD_W-1:0] CERT2 = 32'd78;
   localparam logic [WORD_W-1:0] CERT3 = 32'd89;

   localparam int MIX_SHIFT    = 30;
   localparam int ADV_SHIFT    = 10;
   localparam int TEMPER_SHIFT = 8;

   // Operation codes carried in req_tuser.
   localparam logic [REQ_USER_W-1:0] OP_SEED     = 2'd0;
   localparam logic [REQ_USER_W-1:0] OP_LOAD     = 2'd1;
   localparam logic [REQ_USER_W-1:0] OP_GENERATE = 2'd2;

   // Microcode addresses that the sequencer refers to by name.
   localparam logic [PC_W-1:0] PC_DISPATCH = 5'd0;
   localparam logic [PC_W-1:0] PC_INIT     = 5'd1;
   localparam logic [PC_W-1:0] PC_ADV      = 5'd18;

   // Number of extra passes of the advance step after the first one.
   localparam logic [KONST_W-1:0] ADV_LOOPS = 3'd7;

   typedef logic [3:0][WORD_W-1:0] state_type;

   typedef enum logic [3:0] {
      U_DISPATCH,
      U_INIT,
      U_MUL,
      U_MIX,
      U_ROT,
      U_CERT,
      U_ADV,
      U_LOAD,
      U_GEN,
      U_CAPTURE
   } uop_type;

   typedef struct packed {
      uop_type             uop;
      logic [KONST_W-1:0]  konst;
      logic [PC_W-1:0]     nxt;
      logic [PC_W-1:0]     tgt;
   } ctl_type;

   typedef struct packed {
      uop_type             uop;
      logic [KONST_W-1:0]  konst;
   } act_type;

   // Seed program: init, seven multiply/xor pairs that rotate the words,
   // one rotate to realign, certification, then an advance loop.
   function automatic ctl_type microcode(input logic [PC_W-1:0] pc);
      ctl_type w;
      case (pc)
         5'd0:    w = '{U_DISPATCH, 3'd0, 5'd0,  PC_INIT};
         5'd1:    w = '{U_INIT,     3'd0, 5'd2,  5'd0};
         5'd2:    w = '{U_MUL,      3'd1, 5'd3,  5'd0};
         5'd3:    w = '{U_MIX,      3'd1, 5'd4,  5'd0};
         5'd4:    w = '{U_MUL,      3'd2, 5'd5,  5'd0};
         5'd5:    w = '{U_MIX,      3'd2, 5'd6,  5'd0};
         5'd6:    w = '{U_MUL,      3'd3, 5'd7,  5'd0};
         5'd7:    w = '{U_MIX,      3'd3, 5'd8,  5'd0};
         5'd8:    w = '{U_MUL,      3'd4, 5'd9,  5'd0};
         5'd9:    w = '{U_MIX,      3'd4, 5'd10, 5'd0};
         5'd10:   w = '{U_MUL,      3'd5, 5'd11, 5'd0};
         5'd11:   w = '{U_MIX,      3'd5, 5'd12, 5'd0};
         5'd12:   w = '{U_MUL,      3'd6, 5'd13, 5'd0};
         5'd13:   w = '{U_MIX,      3'd6, 5'd14, 5'd0};
         5'd14:   w = '{U_MUL,      3'd7, 5'd15, 5'd0};
         5'd15:   w = '{U_MIX,      3'd7, 5'd16, 5'd0};
         5'd16:   w = '{U_ROT,      3'd0, 5'd17, 5'd0};
         5'd17:   w = '{U_CERT,     ADV_LOOPS, PC_ADV, 5'd0};
         5'd18:   w = '{U_ADV,      3'd0, PC_DISPATCH, PC_ADV};
         default: w = '{U_DISPATCH, 3'd0, PC_DISPATCH, PC_INIT};
      endcase
      return w;
   endfunction

   function automatic state_type certify(input state_type s);
      state_type r;
      r = s;
      if (((s[0] & MASK) == '0) && (s[1] == '0) && (s[2] == '0) && (s[3] == '0)) begin
         r[0] = CERT0;
         r[1] = CERT1;
         r[2] = CERT2;
         r[3] = CERT3;
      end
      return r;
   endfunction

   function automatic state_type advance(input state_type s);
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      state_type         r;
      y = s[3];
      x = (s[0] & MASK) ^ s[1] ^ s[2];
      x = x ^ (x << 1);
      y = y ^ (y >> 1) ^ x;
      r[0] = s[1];
      r[1] = s[2];
      r[2] = x ^ (y << ADV_SHIFT);
      r[3] = y;
      if (y[0]) begin
         r[1] = r[1] ^ MAT1;
         r[2] = r[2] ^ MAT2;
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] temper(input state_type s);
      logic [WORD_W-1:0] t0;
      logic [WORD_W-1:0] t1;
      t1 = s[0] + (s[2] >> TEMPER_SHIFT);
      t0 = s[3] ^ t1;
      if (t1[0]) begin
         t0 = t0 ^ TMAT;
      end
      return t0;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tinymt32_random_generator.sv
// TinyMT 32-bit generator top level: microcode sequencer, stream ports, result register.
//
// Each word on req carries an operation in req_tuser: generate advances the state
// and returns one tempered 32-bit word on rsp; load writes four state words (an
// all-zero state becomes 84, 73, 78, 89); seed runs the seeding program from a
// read-only microcode table. Generate and load are done at the dispatch step, so
// generate words can be accepted every cycle while the result register drains. A
// seed word occupies the sequencer after it is accepted (init, seven multiply/xor
// pairs through the one multiplier, a realign, certification and eight advances),
// and req_tready stays low meanwhile. After reset the same program runs with a zero
// seed, so the first word is accepted only once that program is done.
`default_nettype none

module tinymt32_random_generator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // req_tdata from bit 0: seed, load_word0, load_word1, load_word2, load_word3
   input  wire logic [tmt32_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser from bit 0: operation
   input  wire logic [tmt32_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // rsp_tdata from bit 0: random_value
   output logic      [tmt32_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import tmt32_pkg::*;

   logic [PC_W-1:0]       pc_ff;
   logic [PC_W-1:0]       pc_in;
   logic [KONST_W-1:0]    cnt_ff;
   logic [KONST_W-1:0]    cnt_in;
   logic                  rsp_tvalid_ff;
   logic                  rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_in;
   ctl_type               ctl;
   act_type               act;
   logic                  req_fire;
   logic                  gen_fire;
   logic [WORD_W-1:0]     gen_value;

   assign ctl        = microcode(pc_ff);
   assign req_tready = (ctl.uop == U_DISPATCH) && (!rsp_tvalid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign gen_fire   = req_fire && (req_tuser == OP_GENERATE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // At the dispatch step the incoming word picks the operation.
   always_comb begin
      act.uop   = ctl.uop;
      act.konst = ctl.konst;
      if ((ctl.uop == U_DISPATCH) && req_fire) begin
         unique case (req_tuser)
            OP_SEED:     act.uop = U_CAPTURE;
            OP_LOAD:     act.uop = U_LOAD;
            OP_GENERATE: act.uop = U_GEN;
            default:     act.uop = U_DISPATCH;
         endcase
      end
   end

   always_comb begin
      pc_in  = ctl.nxt;
      cnt_in = cnt_ff;
      unique case (ctl.uop)
         U_DISPATCH: begin
            pc_in = (act.uop == U_CAPTURE) ? ctl.tgt : pc_ff;
         end
         U_CERT: cnt_in = ctl.konst;
         U_ADV: begin
            if (cnt_ff != '0) begin
               pc_in  = ctl.tgt;
               cnt_in = cnt_ff - KONST_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (gen_fire) begin
         rsp_tdata_in  = gen_value;
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      if (reset) begin
         pc_ff         <= PC_INIT;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   tmt32_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .act        (act),
      .seed       (req_tdata[WORD_W-1:0]),
      .load_words (state_type'(req_tdata[REQ_DATA_W-1:WORD_W])),
      .gen_value  (gen_value)
   );

   // A new result appears only for an accepted generate word.
   a_rsp_from_generate: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(gen_fire))
      else $error("result raised without a generate word");

   // The seeding program never takes input words.
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (pc_ff != PC_DISPATCH) |-> !req_tready)
      else $error("input accepted while the seed program runs");

   // The advance loop either repeats itself or returns to dispatch.
   a_adv_loop_exit: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_ADV) |=> ((pc_ff == PC_ADV) || (pc_ff == PC_DISPATCH)))
      else $error("advance loop left to a wrong step");

   // A result still waiting is held until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |=> (rsp_tvalid_ff && $stable(rsp_tdata_ff)))
      else $error("pending result lost or changed");

endmodule

`default_nettype wire

FILE: rtl/core/tmt32_datapath.sv
// State words, product register and the operations that the sequencer issues.
`default_nettype none

module tmt32_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tmt32_pkg::act_type            act,
   input  wire logic [tmt32_pkg::WORD_W-1:0]  seed,
   input  wire tmt32_pkg::state_type          load_words,
   output logic      [tmt32_pkg::WORD_W-1:0]  gen_value
);
   import tmt32_pkg::*;

   state_type         words_ff;
   state_type         words_in;
   logic [WORD_W-1:0] prod_ff;
   logic [WORD_W-1:0] prod_in;
   logic [WORD_W-1:0] seed_ff;
   logic [WORD_W-1:0] seed_in;
   logic [WORD_W-1:0] mix_src;
   state_type         adv_words;

   assign adv_words = advance(words_ff);
   assign gen_value = temper(adv_words);
   assign mix_src   = words_ff[0] ^ (words_ff[0] >> MIX_SHIFT);

   always_comb begin
      words_in = words_ff;
      prod_in  = prod_ff;
      seed_in  = seed_ff;
      unique case (act.uop)
         U_DISPATCH: ;
         U_CAPTURE:  seed_in = seed;
         U_LOAD:     words_in = certify(load_words);
         U_GEN:      words_in = adv_words;
         U_INIT: begin
            words_in[0] = seed_ff;
            words_in[1] = MAT1;
            words_in[2] = MAT2;
            words_in[3] = TMAT;
         end
         U_MUL:      prod_in = WORD_W'(MULT * mix_src);
         // Word 1 takes the mix, then every word moves down one place so the
         // next step again reads word 0 and writes word 1.
         U_MIX: begin
            words_in[0] = words_ff[1] ^ (prod_ff + WORD_W'(act.konst));
            words_in[1] = words_ff[2];
            words_in[2] = words_ff[3];
            words_in[3] = words_ff[0];
         end
         U_ROT: begin
            words_in[0] = words_ff[1];
            words_in[1] = words_ff[2];
            words_in[2] = words_ff[3];
            words_in[3] = words_ff[0];
         end
         U_CERT:     words_in = certify(words_ff);
         U_ADV:      words_in = adv_words;
         default:    ;
      endcase
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
      prod_ff  <= prod_in;
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

endmodule

`default_nettype wire
